### src/inverse_distance_interpolator_macros.svh
// Assertion macros for the inverse distance interpolator.
// Users must have clk and rst_n in scope.
`ifndef INVERSE_DISTANCE_INTERPOLATOR_MACROS_SVH
`define INVERSE_DISTANCE_INTERPOLATOR_MACROS_SVH

// Check prop on every clock edge outside reset.
`define IDI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds on the cycle after ante.
`define IDI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/idi_pkg.sv
// Shared types and constants for the inverse distance interpolator.
// No dependencies.
package idi_pkg;

    localparam int IDI_MAX_POINTS = 128;
    localparam int WEIGHT_SHIFT   = 36;
    localparam int DIV_W          = 64;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_HIT    = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic [1:0] CM_NONE = 2'd0;
    localparam logic [1:0] CM_RB   = 2'd1;
    localparam logic [1:0] CM_BGR  = 2'd2;
    localparam logic [1:0] CM_GRAY = 2'd3;

    localparam logic [1:0] DSEL_WEIGHT = 2'd0;
    localparam logic [1:0] DSEL_FINAL  = 2'd1;
    localparam logic [1:0] DSEL_COLA   = 2'd2;
    localparam logic [1:0] DSEL_COLB   = 2'd3;

    localparam logic [1:0] CM_RESET = CM_RB;

    typedef struct packed {
        logic       ld_en;
        logic       clr_en;
        logic       q_cap;
        logic       idx_clr;
        logic       rd_en;
        logic       sq_en;
        logic       d2_en;
        logic       div_start;
        logic [1:0] div_sel;
        logic       mul_en;
        logic       acc_en;
        logic       fix_en;
        logic       hit_en;
        logic       empty_en;
        logic       cola_en;
        logic       colb_en;
        logic       out_load;
    } idi_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last;
        logic d2_zero;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } idi_sts_t;

endpackage

### src/idi_divider.sv
// Iterative radix-2 restoring divider, unsigned, one quotient bit per cycle.
// Depends on idi_pkg.
module idi_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [idi_pkg::DIV_W-1:0] dividend,
    input  logic [idi_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [idi_pkg::DIV_W-1:0] quotient,
    output logic [idi_pkg::DIV_W-1:0] remainder
);
    import idi_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] q_reg;
    logic [DIV_W-1:0] r_reg;
    logic [DIV_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] diff;

    assign shifted = {r_reg, q_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W+1])
            begin
                r_reg <= diff[DIV_W-1:0];
                q_reg <= {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[DIV_W-1:0];
                q_reg <= {q_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

### src/idi_datapath.sv
// Datapath: sample store, distance and weight arithmetic, accumulators,
// color mapping and output register. Depends on idi_pkg and idi_divider.
module idi_datapath #(
    parameter int MAX_POINTS = idi_pkg::IDI_MAX_POINTS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [15:0]       coord_x,
    input  logic signed [15:0]       coord_y,
    input  logic signed [15:0]       sample_value,
    input  logic [1:0]               color_mode,
    input  idi_pkg::idi_cmd_t        cmd,
    output idi_pkg::idi_sts_t        sts,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [15:0]       interpolated,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic [1:0]               status
);
    import idi_pkg::*;

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    logic [47:0]        mem [MAX_POINTS];
    logic [47:0]        rd_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic signed [15:0] min_reg;
    logic signed [15:0] max_reg;
    logic signed [15:0] qx_reg;
    logic signed [15:0] qy_reg;
    logic [31:0]        sqx_reg;
    logic [31:0]        sqy_reg;
    logic [32:0]        d2_reg;
    logic signed [53:0] prod_reg;
    logic signed [63:0] num_reg;
    logic signed [63:0] den_reg;
    logic signed [15:0] result_reg;
    logic [1:0]         status_reg;
    logic [7:0]         cola_reg;
    logic [7:0]         colb_reg;
    logic               out_valid_reg;
    logic signed [15:0] interp_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic [1:0]         ostat_reg;

    logic               full;
    logic               store_en;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pv;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] dxx;
    logic signed [33:0] dyy;
    logic signed [63:0] n2;
    logic [63:0]        n2_mag;
    logic signed [64:0] qs;
    logic [16:0]        span;
    logic signed [17:0] o18;
    logic [16:0]        off;
    logic signed [18:0] s19;
    logic [18:0]        s_abs;
    logic [16:0]        a;
    logic [24:0]        num_a;
    logic [24:0]        num_b;
    logic [DIV_W-1:0]   dv_n;
    logic [DIV_W-1:0]   dv_d;
    logic [DIV_W-1:0]   quot;
    logic [DIV_W-1:0]   rem;
    logic               dv_busy;
    logic               dv_done;
    logic [7:0]         r_c;
    logic [7:0]         g_c;
    logic [7:0]         b_c;

    assign full     = (count_reg == CNT_W'(MAX_POINTS));
    assign store_en = cmd.ld_en && !full;

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= {coord_x, coord_y, sample_value};
        end
        if (cmd.rd_en)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.clr_en)
            begin
                count_reg <= '0;
                min_reg   <= '0;
                max_reg   <= '0;
            end
            else if (store_en)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == '0 || sample_value < min_reg)
                begin
                    min_reg <= sample_value;
                end
                if (count_reg == '0 || sample_value > max_reg)
                begin
                    max_reg <= sample_value;
                end
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.acc_en)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign px  = rd_reg[47:32];
    assign py  = rd_reg[31:16];
    assign pv  = rd_reg[15:0];
    assign dx  = {qx_reg[15], qx_reg} - {px[15], px};
    assign dy  = {qy_reg[15], qy_reg} - {py[15], py};
    assign dxx = dx * dx;
    assign dyy = dy * dy;

    assign n2     = (num_reg <<< 1) + den_reg;
    assign n2_mag = n2[63] ? 64'(-n2) : 64'(n2);

    assign span  = 17'({max_reg[15], max_reg} - {min_reg[15], min_reg});
    assign o18   = {{2{result_reg[15]}}, result_reg} - {{2{min_reg[15]}}, min_reg};
    always_comb
    begin
        if (o18 < 0)
        begin
            off = '0;
        end
        else if (o18 > $signed({1'b0, span}))
        begin
            off = span;
        end
        else
        begin
            off = o18[16:0];
        end
    end
    assign s19   = $signed({1'b0, off, 1'b0}) - $signed({2'b00, span});
    assign s_abs = s19[18] ? 19'(-s19) : 19'(s19);
    assign a     = s_abs[16:0];

    always_comb
    begin
        case (color_mode)
            CM_BGR:
            begin
                num_a = 25'(a) * 25'd255;
                num_b = 25'(span - a) * 25'd255;
            end
            CM_GRAY:
            begin
                num_a = 25'(off) * 25'd254;
                num_b = 25'(off) * 25'd254;
            end
            default:
            begin
                num_a = 25'(span - off) * 25'd254;
                num_b = 25'(off) * 25'd254;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_WEIGHT:
            begin
                dv_n = DIV_W'(1) << WEIGHT_SHIFT;
                dv_d = DIV_W'(d2_reg);
            end
            DSEL_FINAL:
            begin
                dv_n = n2_mag;
                dv_d = 64'(den_reg) << 1;
            end
            DSEL_COLA:
            begin
                dv_n = DIV_W'(num_a);
                dv_d = DIV_W'(span);
            end
            default:
            begin
                dv_n = DIV_W'(num_b);
                dv_d = DIV_W'(span);
            end
        endcase
    end

    idi_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dv_n),
        .divisor   (dv_d),
        .busy      (dv_busy),
        .done      (dv_done),
        .quotient  (quot),
        .remainder (rem)
    );

    always_comb
    begin
        if (n2[63])
        begin
            qs = -$signed({1'b0, quot}) - $signed({64'd0, (rem != '0)});
        end
        else
        begin
            qs = $signed({1'b0, quot});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_cap)
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
        end
        if (cmd.sq_en)
        begin
            sqx_reg <= dxx[31:0];
            sqy_reg <= dyy[31:0];
        end
        if (cmd.d2_en)
        begin
            d2_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
        if (cmd.mul_en)
        begin
            prod_reg <= $signed({1'b0, quot[WEIGHT_SHIFT:0]}) * pv;
        end
        if (cmd.idx_clr)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            num_reg <= num_reg + {{10{prod_reg[53]}}, prod_reg};
            den_reg <= den_reg + $signed({27'd0, quot[WEIGHT_SHIFT:0]});
        end
        if (cmd.fix_en)
        begin
            status_reg <= ST_INTERP;
            if (qs < -65'sd32768)
            begin
                result_reg <= -16'sd32768;
            end
            else if (qs > 65'sd32767)
            begin
                result_reg <= 16'sd32767;
            end
            else
            begin
                result_reg <= qs[15:0];
            end
        end
        else if (cmd.hit_en)
        begin
            result_reg <= pv;
            status_reg <= ST_HIT;
        end
        else if (cmd.empty_en)
        begin
            result_reg <= '0;
            status_reg <= ST_EMPTY;
        end
        if (cmd.cola_en)
        begin
            cola_reg <= quot[7:0];
        end
        if (cmd.colb_en)
        begin
            colb_reg <= quot[7:0];
        end
    end

    always_comb
    begin
        r_c = '0;
        g_c = '0;
        b_c = '0;
        if (status_reg != ST_EMPTY)
        begin
            case (color_mode)
                CM_RB:
                begin
                    r_c = (span == '0) ? 8'd127 : cola_reg;
                    b_c = (span == '0) ? 8'd127 : colb_reg;
                end
                CM_BGR:
                begin
                    if (span == '0)
                    begin
                        g_c = 8'd255;
                    end
                    else
                    begin
                        r_c = s19[18] ? cola_reg : 8'd0;
                        g_c = colb_reg;
                        b_c = (!s19[18] && s19 != '0) ? cola_reg : 8'd0;
                    end
                end
                CM_GRAY:
                begin
                    r_c = (span == '0) ? 8'd127 : cola_reg;
                    g_c = r_c;
                    b_c = r_c;
                end
                default:
                begin
                    r_c = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            interp_reg <= result_reg;
            red_reg    <= r_c;
            green_reg  <= g_c;
            blue_reg   <= b_c;
            ostat_reg  <= status_reg;
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.last       = (CNT_W'(idx_reg) == count_reg - 1'b1);
    assign sts.d2_zero    = (d2_reg == '0);
    assign sts.div_busy   = dv_busy;
    assign sts.div_done   = dv_done;
    assign sts.out_busy   = out_valid_reg && out_stall;

    assign out_valid    = out_valid_reg;
    assign interpolated = interp_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign status       = ostat_reg;

endmodule

### src/idi_ctrl.sv
// Controller: sequences loads, clears and the per-point query walk.
// Depends on idi_pkg and the assertion macro header.
module idi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  idi_pkg::idi_sts_t sts,
    output idi_pkg::idi_cmd_t cmd
);
    import idi_pkg::*;
    `include "inverse_distance_interpolator_macros.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_D2    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_WDIV  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_FDIV  = 4'd8;
    localparam logic [3:0] S_FWAIT = 4'd9;
    localparam logic [3:0] S_FIX   = 4'd10;
    localparam logic [3:0] S_CA    = 4'd11;
    localparam logic [3:0] S_CAW   = 4'd12;
    localparam logic [3:0] S_CB    = 4'd13;
    localparam logic [3:0] S_CBW   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        OP_LOAD:
                        begin
                            cmd.ld_en = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clr_en = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            if (sts.count_zero)
                            begin
                                cmd.empty_en = 1'b1;
                                state_next   = S_OUT;
                            end
                            else
                            begin
                                cmd.q_cap   = 1'b1;
                                cmd.idx_clr = 1'b1;
                                state_next  = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.sq_en  = 1'b1;
                state_next = S_D2;
            end
            S_D2:
            begin
                cmd.d2_en  = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.d2_zero)
                begin
                    cmd.hit_en = 1'b1;
                    state_next = S_CA;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_WEIGHT;
                    state_next    = S_WDIV;
                end
            end
            S_WDIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = sts.last ? S_FDIV : S_RD;
            end
            S_FDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_FINAL;
                state_next    = S_FWAIT;
            end
            S_FWAIT:
            begin
                cmd.div_sel = DSEL_FINAL;
                if (sts.div_done)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cmd.div_sel = DSEL_FINAL;
                cmd.fix_en  = 1'b1;
                state_next  = S_CA;
            end
            S_CA:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_COLA;
                state_next    = S_CAW;
            end
            S_CAW:
            begin
                if (sts.div_done)
                begin
                    cmd.cola_en = 1'b1;
                    state_next  = S_CB;
                end
            end
            S_CB:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_COLB;
                state_next    = S_CBW;
            end
            S_CBW:
            begin
                if (sts.div_done)
                begin
                    cmd.colb_en = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    `IDI_ASSERT(a_div_free, !(cmd.div_start && sts.div_busy), "divider restarted while busy")
    `IDI_ASSERT(a_out_free, !(cmd.out_load && sts.out_busy), "result overwrote a held beat")
    `IDI_ASSERT(a_rd_nonempty, !(cmd.rd_en && sts.count_zero), "store read while empty")
    `IDI_ASSERT_NEXT(a_load_back, cmd.out_load, !in_stall, "block not idle after result")

endmodule

### src/inverse_distance_interpolator.sv
// Shepard inverse distance interpolator, power 2, with color mapping.
// Top level: configuration port, controller and datapath. Depends on idi_pkg, idi_ctrl and idi_datapath.
//
// Load and clear beats are handled in the idle state and do not stall the input.
// A query walks the stored points in load order, one point at a time, each
// weight 2^36 / squared distance formed by the shared 64-step radix-2
// divider; the final average and the two color scalings take three more
// passes through the same divider. A query that lands on a stored point stops
// the walk there and skips the final average. An empty store answers with no
// walk and no division. A finished result waits in the output register while
// the next beat is taken in.
module inverse_distance_interpolator #(
    parameter int MAX_POINTS = idi_pkg::IDI_MAX_POINTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic signed [15:0] sample_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] interpolated,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic [1:0]         status
);
    import idi_pkg::*;

    logic [1:0] color_mode_reg;
    idi_cmd_t   cmd;
    idi_sts_t   sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= CM_RESET;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            color_mode_reg <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {30'd0, color_mode_reg};

    idi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    idi_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .sample_value (sample_value),
        .color_mode   (color_mode_reg),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .interpolated (interpolated),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .status       (status)
    );

endmodule

### tb/tb_top.sv
// Self-checking testbench for inverse_distance_interpolator: a queue-fed driver,
// a result monitor and an in-line Shepard predictor with its own copy of the state.
// Depends on idi_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
    import idi_pkg::*;

    localparam int  NPTS        = IDI_MAX_POINTS;
    localparam int  DRAIN_WAIT  = 400;
    localparam longint CYCLE_CAP = 3000000;

    localparam logic [1:0] OP_IGNORED     = 2'd3;
    localparam logic [2:0] REG_COLOR_MODE = 3'd0;
    localparam logic [2:0] REG_UNMAPPED   = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] v;
    } sample_beat_t;

    typedef struct packed {
        logic signed [15:0] interp;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [1:0]         st;
    } pixel_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] sample_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] interpolated;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [1:0]         status;

    sample_beat_t pending_beats[$];
    pixel_t       expected_pixels[$];

    int          send_idle_pct;
    int          recv_idle_pct;
    int          errors;
    int          n_loads;
    int          n_queries;
    int          n_checked;
    longint      cycles;

    int          mdl_x[NPTS];
    int          mdl_y[NPTS];
    int          mdl_v[NPTS];
    int          mdl_count;
    int          mdl_min;
    int          mdl_max;
    logic [1:0]  mdl_mode;

    int          gen_x[NPTS];
    int          gen_y[NPTS];
    int          gen_count;

    inverse_distance_interpolator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .interpolated (interpolated),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .status       (status)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic pixel_t shade(input int val, input logic [1:0] st);
        pixel_t px;
        int     span;
        int     off;
        int     s;
        int     a;
        px = '0;
        px.interp = val[15:0];
        px.st = st;
        span = mdl_max - mdl_min;
        if (mdl_mode == CM_NONE)
            return px;
        if (mdl_max <= mdl_min)
        begin
            if (mdl_mode == CM_RB)
            begin
                px.r = 8'd127;
                px.b = 8'd127;
            end
            else if (mdl_mode == CM_BGR)
                px.g = 8'd255;
            else
            begin
                px.r = 8'd127;
                px.g = 8'd127;
                px.b = 8'd127;
            end
            return px;
        end
        off = val - mdl_min;
        if (off < 0)
            off = 0;
        if (off > span)
            off = span;
        s = 2 * off - span;
        a = (s < 0) ? -s : s;
        if (mdl_mode == CM_RB)
        begin
            px.r = 8'((254 * (span - off)) / span);
            px.b = 8'((254 * off) / span);
        end
        else if (mdl_mode == CM_BGR)
        begin
            px.r = (s < 0) ? 8'((255 * a) / span) : 8'd0;
            px.g = 8'((255 * (span - a)) / span);
            px.b = (s > 0) ? 8'((255 * a) / span) : 8'd0;
        end
        else
        begin
            px.r = 8'((254 * off) / span);
            px.g = px.r;
            px.b = px.r;
        end
        return px;
    endfunction

    function automatic pixel_t interpolate_at(input int qx, input int qy);
        longint num;
        longint den;
        longint dx;
        longint dy;
        longint d2;
        longint w;
        longint n2;
        longint dd;
        longint q;
        pixel_t px;
        num = 0;
        den = 0;
        if (mdl_count == 0)
        begin
            px = '0;
            px.st = ST_EMPTY;
            return px;
        end
        for (int i = 0; i < mdl_count; i++)
        begin
            dx = qx - mdl_x[i];
            dy = qy - mdl_y[i];
            d2 = dx * dx + dy * dy;
            if (d2 == 0)
                return shade(mdl_v[i], ST_HIT);
            w = (64'sd1 <<< WEIGHT_SHIFT) / d2;
            num += w * mdl_v[i];
            den += w;
        end
        n2 = 2 * num + den;
        dd = 2 * den;
        q = n2 / dd;
        if ((n2 % dd) != 0 && n2 < 0)
            q -= 1;
        if (q < -32768)
            q = -32768;
        if (q > 32767)
            q = 32767;
        return shade(int'(q), ST_INTERP);
    endfunction

    task automatic apply_beat(input sample_beat_t bt);
        if (bt.op == OP_LOAD)
        begin
            n_loads++;
            if (mdl_count < NPTS)
            begin
                mdl_x[mdl_count] = bt.x;
                mdl_y[mdl_count] = bt.y;
                mdl_v[mdl_count] = bt.v;
                if (mdl_count == 0 || bt.v < mdl_min)
                    mdl_min = bt.v;
                if (mdl_count == 0 || bt.v > mdl_max)
                    mdl_max = bt.v;
                mdl_count++;
            end
        end
        else if (bt.op == OP_CLEAR)
        begin
            mdl_count = 0;
            mdl_min = 0;
            mdl_max = 0;
        end
        else if (bt.op == OP_QUERY)
        begin
            n_queries++;
            expected_pixels.push_back(interpolate_at(bt.x, bt.y));
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                apply_beat('{op, coord_x, coord_y, sample_value});
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_beat_t nb;
                    nb = pending_beats.pop_front();
                    in_valid     <= 1'b1;
                    op           <= nb.op;
                    coord_x      <= nb.x;
                    coord_y      <= nb.y;
                    sample_value <= nb.v;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("== FAIL ==");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                errors++;
            end
            else
            begin
                pixel_t ex;
                ex = expected_pixels.pop_front();
                n_checked++;
                if (interpolated !== ex.interp)
                begin
                    $error("interpolated: expected %0d, got %0d", ex.interp, interpolated);
                    errors++;
                end
                if (red !== ex.r)
                begin
                    $error("red: expected %0d, got %0d", ex.r, red);
                    errors++;
                end
                if (green !== ex.g)
                begin
                    $error("green: expected %0d, got %0d", ex.g, green);
                    errors++;
                end
                if (blue !== ex.b)
                begin
                    $error("blue: expected %0d, got %0d", ex.b, blue);
                    errors++;
                end
                if (status !== ex.st)
                begin
                    $error("status: expected %0d, got %0d", ex.st, status);
                    errors++;
                end
            end
        end
    end

    task automatic push(input logic [1:0] o, input int x, input int y, input int v);
        sample_beat_t bt;
        bt.op = o;
        bt.x = x[15:0];
        bt.y = y[15:0];
        bt.v = v[15:0];
        if (o == OP_LOAD && gen_count < NPTS)
        begin
            gen_x[gen_count] = bt.x;
            gen_y[gen_count] = bt.y;
            gen_count++;
        end
        if (o == OP_CLEAR)
            gen_count = 0;
        pending_beats.push_back(bt);
    endtask

    function automatic int rnd16();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(64) - 32;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_beats.size() > 0 || expected_pixels.size() > 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == REG_COLOR_MODE)
            mdl_mode = data[1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_group();
        int k;
        int nq;
        int base;
        int vsel;
        push(OP_CLEAR, rnd16(), rnd16(), rnd16());
        k = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
        vsel = $urandom_range(3);
        base = rnd16();
        for (int i = 0; i < k; i++)
            push(OP_LOAD, rnd16(), rnd16(), (vsel == 0) ? base : rnd16());
        nq = $urandom_range(4, 1);
        for (int i = 0; i < nq; i++)
        begin
            if (gen_count > 0 && $urandom_range(3) == 0)
            begin
                int p;
                p = $urandom_range(gen_count - 1);
                push(OP_QUERY, gen_x[p], gen_y[p], rnd16());
            end
            else
                push(OP_QUERY, rnd16(), rnd16(), rnd16());
        end
        if ($urandom_range(15) == 0)
            push(OP_IGNORED, rnd16(), rnd16(), rnd16());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        op = OP_LOAD;
        coord_x = '0;
        coord_y = '0;
        sample_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        errors = 0;
        n_loads = 0;
        n_queries = 0;
        n_checked = 0;
        cycles = 0;
        mdl_count = 0;
        mdl_min = 0;
        mdl_max = 0;
        mdl_mode = CM_RESET;
        gen_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push(OP_QUERY, 0, 0, 0);
        push(OP_LOAD, -32768, -32768, -32768);
        push(OP_QUERY, -32768, -32768, 0);
        push(OP_QUERY, 32767, 32767, 0);
        push(OP_LOAD, 32767, 32767, 32767);
        push(OP_QUERY, 0, 0, 0);
        push(OP_QUERY, 32767, 32767, -1);
        push(OP_QUERY, 32767, 32766, 0);
        push(OP_QUERY, 100, -2000, 0);
        push(OP_IGNORED, 0, 0, 0);
        push(OP_LOAD, 32767, 32767, 5);
        push(OP_QUERY, 32767, 32767, 0);
        push(OP_CLEAR, 0, 0, 0);
        push(OP_QUERY, 1, 1, 1);
        push(OP_LOAD, 10, 10, 77);
        push(OP_LOAD, -10, -10, 77);
        push(OP_QUERY, 0, 0, 0);
        push(OP_LOAD, 0, 40, -300);
        push(OP_QUERY, 0, 39, 0);
        push(OP_QUERY, 0, -39, 0);
        push(OP_CLEAR, 0, 0, 0);
        wait_idle();
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFC);

        for (int ph = 0; ph < 12; ph++)
        begin
            wait_idle();
            write_reg(REG_COLOR_MODE, {30'($urandom_range(32'h3FFF_FFFF)), 2'(ph % 4)});
            case (ph / 4)
                0: begin send_idle_pct = 25; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 25; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph == 9)
            begin
                push(OP_CLEAR, 0, 0, 0);
                for (int i = 0; i < NPTS + 3; i++)
                    push(OP_LOAD, rnd16(), rnd16(), rnd16());
                push(OP_QUERY, rnd16(), rnd16(), 0);
                push(OP_QUERY, gen_x[NPTS - 1], gen_y[NPTS - 1], 0);
            end
            while (pending_beats.size() < 90)
                random_group();
        end

        wait_idle();
        if (expected_pixels.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_pixels.size());
            errors++;
        end
        $display("covered %0d loads and %0d queries, %0d results checked, %0d errors",
                 n_loads, n_queries, n_checked, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
